// ===== hw/rtl/ssc_pkg.sv =====
// Shared constants, register indexes and helpers for the stride side classifier.
package ssc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int GAIN_W   = 9;
    localparam int THR_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int CONF_W   = 9;
    localparam int CAD_W    = 16;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANDING_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd77;
    localparam logic [THR_W-1:0]  LAND_RESET = 15'd3763;
    localparam logic [THR_W-1:0]  REC_RESET  = 15'd3011;

    // Filter: unity gain and rounding offset (1/256 units)
    localparam logic [GAIN_W-1:0] GAIN_FULL   = 9'd256;
    localparam int                FILT_ACC_W  = 27;
    localparam logic [FILT_ACC_W-1:0] FILT_ROUND = 27'd128;

    // Cadence: 960000 = 15000 << 6 (Q12.4 steps per minute from ms)
    localparam int              CAD_K_W   = 14;
    localparam logic [CAD_K_W-1:0] CAD_K  = 14'd15000;
    localparam int              CAD_SHIFT = 6;
    localparam int              CAD_NUM_W = CNT_W + CAD_K_W + CAD_SHIFT;

    // Confidence limits, Q1.8
    localparam logic [CONF_W-1:0] CONF_AGREE_MAX    = 9'd256;
    localparam logic [CONF_W-1:0] CONF_DISAGREE_MAX = 9'd154;
    // t/3 saturates at 154 once t reaches 465; below that t/3 = (t*683) >> 11
    localparam logic [16:0]       DIV3_LIMIT = 17'd465;
    localparam logic [9:0]        DIV3_MUL   = 10'd683;
    localparam int                DIV3_SHIFT = 11;

    // Magnitude of a signed sample; -32768 maps to 32768
    function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        r = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
        return r;
    endfunction

endpackage

// ===== hw/rtl/stride_side_classifier.sv =====
// Top level: left/right foot landing classifier for IMU samples.
//
// Usage:
//   s_ channel: one IMU sample per beat (three accelerations, yaw rate, time).
//   m_ channel: exactly one result beat per sample (landing flag, foot,
//   confidence, cadence, landing count, echoed time).
//   cfg_ channel: register writes (0 filter gain, 1 landing threshold,
//   2 recovery threshold); always ready, issue only while the block is idle.
// Timing:
//   One sample at a time. Ten squares and products run on bit-serial
//   shift-add lanes; the next sample is accepted only once the widest lane
//   is done and the result is loaded. A landing that follows an earlier
//   landing at a nonzero time also runs the 16-step serial cadence divider,
//   which finishes at once when the quotient saturates.
//   The result is loaded into the output register from the done state,
//   after the multiply, evaluate, classify and, if needed, divide states.
// Reset:
//   aresetn (synchronous, active low) restores register defaults and clears
//   the filters, step state, interval sums and the landing count.
// Stall:
//   A result waiting on m_ready does not block the next sample; if a second
//   result is finished before the first is taken, the block holds it and
//   stops accepting samples until the output register frees up.
module stride_side_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  s_accel_x,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  s_accel_y,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  s_accel_z,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  s_yaw_rate,
    input  logic        [ssc_pkg::TIME_W-1:0]    s_time_ms,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_step_valid,
    output logic                                 m_left_foot,
    output logic        [ssc_pkg::CONF_W-1:0]    m_confidence,
    output logic        [ssc_pkg::CAD_W-1:0]     m_cadence,
    output logic        [ssc_pkg::TIME_W-1:0]    m_step_count,
    output logic        [ssc_pkg::TIME_W-1:0]    m_event_time,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [ssc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssc_pkg::*;

    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int THR2_W = 2 * THR_W;
    localparam int FP_W   = SAMPLE_W + GAIN_W;
    localparam int CADP_W = CNT_W + CAD_K_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0] gain_reg;
    logic [THR_W-1:0]  land_thr_reg;
    logic [THR_W-1:0]  rec_thr_reg;

    // running state
    logic signed [SAMPLE_W-1:0] lat_f_reg;
    logic signed [SAMPLE_W-1:0] yaw_f_reg;
    logic                       in_step_reg;
    logic [TIME_W-1:0]          last_time_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [TIME_W-1:0]          total_reg;

    // per-sample working registers
    logic                       ay_neg_reg;
    logic                       yr_neg_reg;
    logic                       lf_neg_reg;
    logic                       yf_neg_reg;
    logic [TIME_W-1:0]          time_reg;
    logic                       landing_reg;
    logic                       cad_needed_reg;
    logic                       res_left_reg;
    logic [CONF_W-1:0]          res_conf_reg;

    // output register
    logic                       m_valid_reg;
    logic                       m_step_valid_reg;
    logic                       m_left_foot_reg;
    logic [CONF_W-1:0]          m_confidence_reg;
    logic [CAD_W-1:0]           m_cadence_reg;
    logic [TIME_W-1:0]          m_step_count_reg;
    logic [TIME_W-1:0]          m_event_time_reg;

    logic s_accept;
    logic out_load;
    logic mul_start;
    logic div_start;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign mul_start = s_accept;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            land_thr_reg <= LAND_RESET;
            rec_thr_reg  <= REC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FILTER_GAIN:        gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_LANDING_THRESHOLD:  land_thr_reg <= cfg_data[THR_W-1:0];
                REG_RECOVERY_THRESHOLD: rec_thr_reg  <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Serial multiplier lanes, all started on the input beat
    logic [GAIN_W-1:0] gain_clip, gain_comp;
    logic [CNT_W-1:0]  count_inc;

    assign gain_clip = (gain_reg > GAIN_FULL) ? GAIN_FULL : gain_reg;
    assign gain_comp = GAIN_FULL - gain_clip;
    assign count_inc = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
    logic [THR2_W-1:0] land2, rec2;
    logic [FP_W-1:0]   p_lat_new, p_lat_old, p_yaw_new, p_yaw_old;
    logic [CADP_W-1:0] p_cad;
    logic [9:0]        lane_busy;
    logic              mul_busy;

    ssc_serial_mul #(.AW(SAMPLE_W), .BW(SAMPLE_W)) u_sq_x (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(s_accel_x)), .b(mag16(s_accel_x)), .busy(lane_busy[0]), .prod(sq_x));
    ssc_serial_mul #(.AW(SAMPLE_W), .BW(SAMPLE_W)) u_sq_y (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(s_accel_y)), .b(mag16(s_accel_y)), .busy(lane_busy[1]), .prod(sq_y));
    ssc_serial_mul #(.AW(SAMPLE_W), .BW(SAMPLE_W)) u_sq_z (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(s_accel_z)), .b(mag16(s_accel_z)), .busy(lane_busy[2]), .prod(sq_z));
    ssc_serial_mul #(.AW(THR_W), .BW(THR_W)) u_land2 (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(land_thr_reg), .b(land_thr_reg), .busy(lane_busy[3]), .prod(land2));
    ssc_serial_mul #(.AW(THR_W), .BW(THR_W)) u_rec2 (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(rec_thr_reg), .b(rec_thr_reg), .busy(lane_busy[4]), .prod(rec2));
    ssc_serial_mul #(.AW(SAMPLE_W), .BW(GAIN_W)) u_lat_new (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(s_accel_y)), .b(gain_clip), .busy(lane_busy[5]), .prod(p_lat_new));
    ssc_serial_mul #(.AW(SAMPLE_W), .BW(GAIN_W)) u_lat_old (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(lat_f_reg)), .b(gain_comp), .busy(lane_busy[6]), .prod(p_lat_old));
    ssc_serial_mul #(.AW(SAMPLE_W), .BW(GAIN_W)) u_yaw_new (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(s_yaw_rate)), .b(gain_clip), .busy(lane_busy[7]), .prod(p_yaw_new));
    ssc_serial_mul #(.AW(SAMPLE_W), .BW(GAIN_W)) u_yaw_old (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mag16(yaw_f_reg)), .b(gain_comp), .busy(lane_busy[8]), .prod(p_yaw_old));
    // cadence numerator for the speculative next interval count
    ssc_serial_mul #(.AW(CNT_W), .BW(CAD_K_W)) u_cad_num (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(count_inc), .b(CAD_K), .busy(lane_busy[9]), .prod(p_cad));

    assign mul_busy = |lane_busy[9:0];

    // ---------------------------------------------------------------
    // Sample registers (signs of filter operands and the timestamp)
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ay_neg_reg <= s_accel_y[SAMPLE_W-1];
            yr_neg_reg <= s_yaw_rate[SAMPLE_W-1];
            lf_neg_reg <= lat_f_reg[SAMPLE_W-1];
            yf_neg_reg <= yaw_f_reg[SAMPLE_W-1];
            time_reg   <= s_time_ms;
        end
    end

    // ---------------------------------------------------------------
    // Evaluation: filter update, landing test, interval bookkeeping
    logic signed [FILT_ACC_W-1:0] lat_acc, yaw_acc;
    logic signed [FILT_ACC_W-1:0] lat_t_new, lat_t_old, yaw_t_new, yaw_t_old;
    logic signed [SAMPLE_W-1:0]   lat_new, yaw_new;
    logic [SQ_W-1:0]              m2;
    logic                         landing_w;
    logic                         recover_w;
    logic                         has_prior;
    logic [TIME_W-1:0]            interval;
    logic [SUM_W:0]               sum_wide;
    logic [SUM_W-1:0]             sum_sat;

    always_comb begin
        lat_t_new = $signed({2'b00, p_lat_new});
        lat_t_old = $signed({2'b00, p_lat_old});
        yaw_t_new = $signed({2'b00, p_yaw_new});
        yaw_t_old = $signed({2'b00, p_yaw_old});
        if (ay_neg_reg) lat_t_new = -lat_t_new;
        if (lf_neg_reg) lat_t_old = -lat_t_old;
        if (yr_neg_reg) yaw_t_new = -yaw_t_new;
        if (yf_neg_reg) yaw_t_old = -yaw_t_old;
        lat_acc = lat_t_new + lat_t_old + $signed(FILT_ROUND);
        yaw_acc = yaw_t_new + yaw_t_old + $signed(FILT_ROUND);
        // weighted average always fits 16 bits after the divide by 256
        lat_new = lat_acc[SAMPLE_W+7:8];
        yaw_new = yaw_acc[SAMPLE_W+7:8];
    end

    always_comb begin
        m2        = sq_x + sq_y + sq_z;
        landing_w = (m2 > SQ_W'(land2)) && !in_step_reg;
        recover_w = (m2 < SQ_W'(rec2));
        has_prior = (last_time_reg != '0);
        interval  = time_reg - last_time_reg;
        sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(interval);
        sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end

    assign div_start = (state_reg == ST_EVAL) && landing_w && has_prior;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_f_reg     <= '0;
            yaw_f_reg     <= '0;
            in_step_reg   <= 1'b0;
            last_time_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
        end else if (state_reg == ST_EVAL) begin
            lat_f_reg <= lat_new;
            yaw_f_reg <= yaw_new;
            if (landing_w) begin
                in_step_reg   <= 1'b1;
                last_time_reg <= time_reg;
                total_reg     <= total_reg + 1'b1;
                if (has_prior) begin
                    sum_reg   <= sum_sat;
                    count_reg <= count_inc;
                end
            end else if (recover_w) begin
                in_step_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EVAL) begin
            landing_reg    <= landing_w;
            cad_needed_reg <= landing_w && has_prior;
        end
    end

    // ---------------------------------------------------------------
    // Cadence divider: 960000 * count / interval sum
    logic [CAD_W-1:0] div_quo;
    logic             div_busy;

    ssc_serial_div #(.NW(CAD_NUM_W), .DW(SUM_W), .QW(CAD_W)) u_cad_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({p_cad, {CAD_SHIFT{1'b0}}}),
        .den     (sum_sat),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    // ---------------------------------------------------------------
    // Foot choice and confidence from the updated filter values
    logic [SAMPLE_W-1:0] lat_mag, yaw_mag;
    logic [16:0]         mag_sum;
    logic                lat_left, yaw_left, agree, left_w;
    logic [18:0]         div3_prod;
    logic [CONF_W-1:0]   conf_agree, conf_disagree, conf_w;

    always_comb begin
        lat_mag   = mag16(lat_f_reg);
        yaw_mag   = mag16(yaw_f_reg);
        mag_sum   = {1'b0, lat_mag} + {1'b0, yaw_mag};
        lat_left  = !lat_f_reg[SAMPLE_W-1] && (lat_f_reg != '0);
        yaw_left  = !yaw_f_reg[SAMPLE_W-1] && (yaw_f_reg != '0);
        agree     = (lat_left && yaw_left) ||
                    (lat_f_reg[SAMPLE_W-1] && yaw_f_reg[SAMPLE_W-1]);
        if (lat_left == yaw_left) begin
            left_w = lat_left;
        end else begin
            left_w = (lat_mag > yaw_mag) ? lat_left : yaw_left;
        end
        conf_agree    = (mag_sum[16:1] > 16'(CONF_AGREE_MAX)) ? CONF_AGREE_MAX
                                                              : mag_sum[CONF_W:1];
        div3_prod     = mag_sum[8:0] * DIV3_MUL;
        conf_disagree = (mag_sum >= DIV3_LIMIT) ? CONF_DISAGREE_MAX
                                                : {1'b0, div3_prod[18:DIV3_SHIFT]};
        conf_w        = agree ? conf_agree : conf_disagree;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLASS) begin
            res_left_reg <= landing_reg && left_w;
            res_conf_reg <= landing_reg ? conf_w : '0;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_MUL;
            ST_MUL:   if (!mul_busy) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_CLASS;
            ST_CLASS: state_next = cad_needed_reg ? ST_DIV : ST_DONE;
            ST_DIV:   if (!div_busy) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_step_valid_reg <= landing_reg;
            m_left_foot_reg  <= res_left_reg;
            m_confidence_reg <= res_conf_reg;
            m_cadence_reg    <= cad_needed_reg ? div_quo : '0;
            m_step_count_reg <= total_reg;
            m_event_time_reg <= time_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_step_valid = m_step_valid_reg;
    assign m_left_foot  = m_left_foot_reg;
    assign m_confidence = m_confidence_reg;
    assign m_cadence    = m_cadence_reg;
    assign m_step_count = m_step_count_reg;
    assign m_event_time = m_event_time_reg;

    // ---------------------------------------------------------------
    // Assertions
    assert_lanes_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> !mul_busy)
        else $error("multiplier lanes still running at evaluation");

    assert_landing_sets_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && landing_w) |=> in_step_reg)
        else $error("landing did not set the step state");

    assert_count_only_on_landing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && !landing_w) |=> $stable(total_reg))
        else $error("landing count moved without a landing");

    assert_div_done_at_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !div_busy)
        else $error("cadence divider busy when the result is released");

endmodule

// ===== hw/rtl/ssc_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module ssc_serial_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] prod
);
    localparam int CW = $clog2(BW + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW:0]      part_sum;

    // Add the multiplicand into the upper half when the current bit is set
    always_comb begin
        part_sum = {1'b0, acc_reg[AW+BW-1:BW]} + (acc_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});
        acc_next = {part_sum, acc_reg[BW-1:1]};
    end

    always_comb begin
        if (start) begin
            cnt_next = CW'(BW);
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Operand and product shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            acc_reg <= {{AW{1'b0}}, b};
        end else if (cnt_reg != '0) begin
            acc_reg <= acc_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/ssc_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating at all ones.
module ssc_serial_div #(
    parameter int NW = 44,
    parameter int DW = 40,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [QW-1:0] quo
);
    localparam int CW = $clog2(QW + 1);
    localparam int WW = DW + QW;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg, rem_next;
    // numerator low bits shift out at the top, quotient bits shift in below
    logic [QW-1:0] sh_reg, sh_next;
    logic          sat;
    logic [DW:0]   trial, diff;
    logic          ge;

    // Quotient overflows (or divisor is zero) when num >= den * 2^QW
    assign sat = (WW'(num) >= {den, {QW{1'b0}}});

    always_comb begin
        trial    = {rem_reg, sh_reg[QW-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        sh_next  = {sh_reg[QW-2:0], ge};
    end

    always_comb begin
        if (start) begin
            cnt_next = sat ? '0 : CW'(QW);
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Datapath: load, then one step per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= DW'(num[NW-1:QW]);
            sh_reg  <= sat ? {QW{1'b1}} : num[QW-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = sh_reg;

endmodule

// ===== verif/stride_side_classifier_tb.sv =====
// Self-checking testbench for the stride side classifier: directed and random IMU beats.
`timescale 1ns / 1ps

module stride_side_classifier_tb;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 48;     // extra wait once every owed result is back
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] yaw;
        logic        [TIME_W-1:0]   t;
    } imu_sample_t;

    typedef struct packed {
        logic              step;
        logic              left;
        logic [CONF_W-1:0] conf;
        logic [CAD_W-1:0]  cad;
        logic [TIME_W-1:0] count;
        logic [TIME_W-1:0] etime;
    } stride_result_t;

    // Landing / foot / cadence predictor plus the queue of results still owed
    class stride_predictor;
        logic [GAIN_W-1:0]          gain;
        logic [THR_W-1:0]           land_thr;
        logic [THR_W-1:0]           rec_thr;
        logic signed [SAMPLE_W-1:0] lat_filt;
        logic signed [SAMPLE_W-1:0] yaw_filt;
        logic                       in_step;
        logic [TIME_W-1:0]          last_landing;
        logic [SUM_W-1:0]           interval_sum;
        logic [CNT_W-1:0]           interval_cnt;
        logic [TIME_W-1:0]          landings;
        stride_result_t             expected_results[$];
        int                         failures;

        function new();
            gain         = GAIN_RESET;
            land_thr     = LAND_RESET;
            rec_thr      = REC_RESET;
            lat_filt     = '0;
            yaw_filt     = '0;
            in_step      = 1'b0;
            last_landing = '0;
            interval_sum = '0;
            interval_cnt = '0;
            landings     = '0;
            failures     = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FILTER_GAIN:        gain     = data[GAIN_W-1:0];
                REG_LANDING_THRESHOLD:  land_thr = data[THR_W-1:0];
                REG_RECOVERY_THRESHOLD: rec_thr  = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // One low-pass step: weight g/256 on the new sample, rounded, floored
        function logic signed [SAMPLE_W-1:0] smooth(input longint x, input longint prev,
                                                    input longint g);
            longint acc;
            acc = g * x + (256 - g) * prev + 128;
            return SAMPLE_W'(acc >>> 8);
        endfunction

        function void note_sample(input imu_sample_t s);
            longint            g, ax, ay, az, m2, land2, rec2, lmag, ymag, tot;
            logic              lat_left, yaw_left, agree, landing;
            logic [TIME_W-1:0] interval;
            logic [SUM_W:0]    sum_next;
            longint unsigned   quot;
            stride_result_t    r;

            g = (gain > GAIN_FULL) ? GAIN_FULL : gain;
            lat_filt = smooth($signed(s.ay), lat_filt, g);
            yaw_filt = smooth($signed(s.yaw), yaw_filt, g);

            // landing / rearm hysteresis on squared magnitude
            ax = $signed(s.ax);
            ay = $signed(s.ay);
            az = $signed(s.az);
            m2 = ax * ax + ay * ay + az * az;
            land2 = longint'(land_thr) * longint'(land_thr);
            rec2  = longint'(rec_thr) * longint'(rec_thr);
            landing = 1'b0;
            if (m2 > land2 && !in_step) begin
                in_step = 1'b1;
                landing = 1'b1;
            end else if (m2 < rec2) begin
                in_step = 1'b0;
            end

            r = '0;
            if (landing) begin
                lmag = (lat_filt < 0) ? -longint'(lat_filt) : longint'(lat_filt);
                ymag = (yaw_filt < 0) ? -longint'(yaw_filt) : longint'(yaw_filt);
                tot  = lmag + ymag;
                lat_left = (lat_filt > 0);
                yaw_left = (yaw_filt > 0);
                agree = (lat_filt > 0 && yaw_filt > 0) || (lat_filt < 0 && yaw_filt < 0);

                // signs agree: take it; else the larger magnitude, yaw on a tie
                if (lat_left == yaw_left) r.left = lat_left;
                else                      r.left = (lmag > ymag) ? lat_left : yaw_left;

                if (agree)
                    r.conf = (tot / 2 > CONF_AGREE_MAX) ? CONF_AGREE_MAX : CONF_W'(tot / 2);
                else
                    r.conf = (tot / 3 > CONF_DISAGREE_MAX) ? CONF_DISAGREE_MAX
                                                           : CONF_W'(tot / 3);

                // cadence only once an earlier (nonzero-time) landing exists
                if (last_landing != 0) begin
                    interval = s.t - last_landing;
                    sum_next = interval_sum + interval;
                    interval_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
                    if (interval_cnt != '1) interval_cnt = interval_cnt + 1'b1;
                    if (interval_sum == 0) begin
                        r.cad = '1;
                    end else begin
                        quot = (64'd960000 * interval_cnt) / interval_sum;
                        r.cad = (quot > 65535) ? '1 : CAD_W'(quot);
                    end
                end
                last_landing = s.t;
                landings = landings + 1'b1;
                r.step = 1'b1;
            end
            r.count = landings;
            r.etime = s.t;
            expected_results.push_back(r);
        endfunction

        function void check_result(input stride_result_t got);
            stride_result_t exp_r;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result beat: step=%0d count=%0d time=%0d",
                             got.step, got.count, got.etime);
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.step !== exp_r.step || got.left !== exp_r.left ||
                got.conf !== exp_r.conf || got.cad !== exp_r.cad ||
                got.count !== exp_r.count || got.etime !== exp_r.etime) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("mismatch: exp step=%0d left=%0d conf=%0d cad=%0d cnt=%0d t=%0d",
                             exp_r.step, exp_r.left, exp_r.conf, exp_r.cad, exp_r.count,
                             exp_r.etime);
                    $display("          got step=%0d left=%0d conf=%0d cad=%0d cnt=%0d t=%0d",
                             got.step, got.left, got.conf, got.cad, got.count, got.etime);
                end
            end
        endfunction
    endclass

    // DUT ports, all inputs known from time zero
    logic                       aclk;
    logic                       aresetn    = 1'b0;
    logic                       s_valid    = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_accel_x  = '0;
    logic signed [SAMPLE_W-1:0] s_accel_y  = '0;
    logic signed [SAMPLE_W-1:0] s_accel_z  = '0;
    logic signed [SAMPLE_W-1:0] s_yaw_rate = '0;
    logic [TIME_W-1:0]          s_time_ms  = '0;
    logic                       m_valid;
    logic                       m_ready    = 1'b0;
    logic                       m_step_valid;
    logic                       m_left_foot;
    logic [CONF_W-1:0]          m_confidence;
    logic [CAD_W-1:0]           m_cadence;
    logic [TIME_W-1:0]          m_step_count;
    logic [TIME_W-1:0]          m_event_time;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;

    // stimulus knobs
    int          gap_max       = 0;
    int          burst_left    = 0;
    int          ready_pct     = 100;
    int          hold_left     = 0;
    bit          hold_request  = 1'b0;
    int          quiet_left    = 0;
    bit          wild_time     = 1'b0;
    logic [31:0] now_ms        = '0;
    int unsigned cycle_count   = 0;

    stride_predictor pred = new();

    stride_side_classifier DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_accel_x    (s_accel_x),
        .s_accel_y    (s_accel_y),
        .s_accel_z    (s_accel_z),
        .s_yaw_rate   (s_yaw_rate),
        .s_time_ms    (s_time_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_step_valid (m_step_valid),
        .m_left_foot  (m_left_foot),
        .m_confidence (m_confidence),
        .m_cadence    (m_cadence),
        .m_step_count (m_step_count),
        .m_event_time (m_event_time),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check accepted beats, stall randomly or on a long hold
    always @(posedge aclk) begin : result_sink
        stride_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_step_valid, m_left_foot, m_confidence, m_cadence,
                    m_step_count, m_event_time};
            pred.check_result(got);
        end
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99, 0) < ready_pct);
        end
    end

    function automatic imu_sample_t imu(input int ax, input int ay, input int az,
                                        input int yr, input logic [TIME_W-1:0] t);
        imu_sample_t s;
        s.ax  = SAMPLE_W'(ax);
        s.ay  = SAMPLE_W'(ay);
        s.az  = SAMPLE_W'(az);
        s.yaw = SAMPLE_W'(yr);
        s.t   = t;
        return s;
    endfunction

    // random magnitude in [lo, hi] with random sign
    function automatic logic signed [SAMPLE_W-1:0] rand_signed(input int unsigned lo,
                                                               input int unsigned hi);
        int m;
        m = $urandom_range(hi, lo);
        return $urandom_range(1, 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    // one sample beat; bursts with random gaps when gap_max is nonzero
    task automatic send_sample(input imu_sample_t s);
        s_valid    <= 1'b1;
        s_accel_x  <= s.ax;
        s_accel_y  <= s.ay;
        s_accel_z  <= s.az;
        s_yaw_rate <= s.yaw;
        s_time_ms  <= s.t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred.note_sample(s);
        if (gap_max != 0 && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge aclk);
            burst_left = $urandom_range(24, 1);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // stop sending and wait until every owed result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pred.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        pred.write_reg(idx, data);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] gain_v,
                                input logic [CFG_DATA_W-1:0] land_v,
                                input logic [CFG_DATA_W-1:0] rec_v);
        drain_results();
        write_reg(REG_FILTER_GAIN, gain_v);
        write_reg(REG_LANDING_THRESHOLD, land_v);
        write_reg(REG_RECOVERY_THRESHOLD, rec_v);
        cfg_valid <= 1'b0;
    endtask

    // mostly landing/rearm sequences with random content, some pure noise
    task automatic run_random(input int n, input int drain_at, input int hold_at);
        imu_sample_t s;
        int          kind;
        for (int i = 0; i < n; i++) begin
            if (i == drain_at) drain_results();
            if (i == hold_at) hold_request = 1'b1;
            kind = $urandom_range(99, 0);
            if (kind < (wild_time ? 10 : 20)) begin
                s.ax  = SAMPLE_W'($urandom);
                s.ay  = SAMPLE_W'($urandom);
                s.az  = SAMPLE_W'($urandom);
                s.yaw = SAMPLE_W'($urandom);
                s.t   = $urandom;
            end else if (quiet_left == 0) begin
                // landing beat: forward accel alone reaches at least the threshold
                s.ax  = rand_signed(32'(pred.land_thr), 32767);
                s.az  = rand_signed(0, 32767);
                s.ay  = $urandom_range(1, 0) ? rand_signed(0, 3000) : SAMPLE_W'($urandom);
                s.yaw = $urandom_range(1, 0) ? rand_signed(0, 3000) : SAMPLE_W'($urandom);
                if (wild_time)
                    now_ms += $urandom_range(32'hFFFF_FFFF, 32'hE000_0000);
                else if ($urandom_range(32, 0) != 0)
                    now_ms += $urandom_range(700, 1);
                s.t = now_ms;
                quiet_left = wild_time ? 1 : $urandom_range(3, 1);
            end else begin
                // rearm beat: every accel component at most half the recovery threshold
                s.ax  = rand_signed(0, 32'(pred.rec_thr / 2));
                s.ay  = rand_signed(0, 32'(pred.rec_thr / 2));
                s.az  = rand_signed(0, 32'(pred.rec_thr / 2));
                s.yaw = SAMPLE_W'($urandom);
                s.t   = now_ms + $urandom_range(1000, 0);
                quiet_left--;
            end
            send_sample(s);
        end
    endtask

    initial begin : main_seq
        logic [CFG_DATA_W-1:0] land_v;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values, no idling
        send_sample(imu(32767, 32767, 32767, 32767, 0));        // landing at time zero
        send_sample(imu(-32768, -32768, -32768, -32768, 16));   // still in step
        send_sample(imu(0, 0, 0, 0, 20));                       // rearm
        send_sample(imu(-32768, 0, 0, 0, 1000));                // earlier landing at time zero does not count
        send_sample(imu(0, 0, 0, 0, 1100));
        send_sample(imu(0, 0, -32768, 0, 1000));                // zero interval sum
        send_sample(imu(0, 0, 0, 0, 1200));
        send_sample(imu(3400, 0, 0, 0, 1250));                  // between thresholds
        send_sample(imu(3764, 0, 0, 0, 1500));                  // just over landing
        send_sample(imu(0, 3400, 0, 0, 1600));                  // between, in step
        send_sample(imu(0, 0, 3010, 0, 1700));                  // just under recovery
        send_sample(imu(3763, 0, 0, 0, 1800));                  // exactly landing level
        send_sample(imu(0, -3011, 0, 0, 1900));                 // exactly recovery level
        send_sample(imu(0, 0, 20000, -1, 32'hFFFF_FFFF));       // landing at max time

        // gain above unity clamps to 256: filtered values follow the input
        apply_config(15'h7FFF, LAND_RESET, REC_RESET);
        send_sample(imu(0, 0, 0, 0, 2000));
        send_sample(imu(20000, 1280, 0, -1280, 2100));          // equal mags, yaw decides
        send_sample(imu(0, 0, 0, 0, 2200));
        send_sample(imu(20000, -1280, 0, 1280, 2300));
        send_sample(imu(0, 0, 0, 0, 2400));
        send_sample(imu(20000, 3000, 0, 200, 2500));            // agree, confidence capped
        send_sample(imu(0, 0, 0, 0, 2600));
        send_sample(imu(20000, 600, 0, -300, 2700));            // lateral larger decides
        send_sample(imu(0, 0, 0, 0, 2800));
        send_sample(imu(20000, 0, 0, 5, 2900));                 // lateral zero
        send_sample(imu(0, 0, 0, 0, 3000));
        send_sample(imu(0, -32768, 0, -32768, 3100));           // agree right, extremes

        now_ms = 32'd5000;

        // reset values again, moderate idling on both sides
        gap_max = 4;
        ready_pct = 70;
        apply_config(CFG_DATA_W'(GAIN_RESET), LAND_RESET, REC_RESET);
        run_random(200, -1, -1);

        // frozen filter, at most one landing, never rearmed
        gap_max = 0;
        ready_pct = 100;
        apply_config(15'd0, 15'd0, 15'd0);
        run_random(60, -1, -1);

        // full-scale thresholds, heavy idling, one full drain mid-phase
        gap_max = 8;
        ready_pct = 40;
        apply_config(CFG_DATA_W'(GAIN_FULL), 15'h7FFF, 15'h7FFF);
        run_random(150, 75, -1);

        // long receiver hold backs the block up into the sample channel
        gap_max = 2;
        ready_pct = 85;
        apply_config(15'h01FF, 15'd5000, 15'd2000);
        run_random(150, -1, 40);

        // random registers; near-wrap intervals push the interval sum to saturation
        gap_max = 6;
        ready_pct = 60;
        wild_time = 1'b1;
        land_v = CFG_DATA_W'($urandom_range(20000, 2000));
        apply_config(CFG_DATA_W'($urandom_range(255, 1)), land_v,
                     CFG_DATA_W'($urandom_range(land_v, 0)));
        run_random(600, -1, -1);

        drain_results();
        if (pred.failures == 0 && pred.expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== stride_side_classifier.f =====
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_serial_mul.sv
hw/rtl/ssc_serial_div.sv
hw/rtl/stride_side_classifier.sv
verif/stride_side_classifier_tb.sv
